// ===== hdl/bmtb_pkg.sv =====
// Shared types, register indexes and constants of the block mean threshold binarizer.
package bmtb_pkg;

  localparam int MAX_GRID_COLS  = 256;
  localparam int MAX_GRID_ROWS  = 256;
  localparam int MAX_CELL_SIDE  = 256;
  localparam int MAX_FRAME_SIDE = 4096;

  localparam int GRAY_THRESHOLD = 127;
  localparam int GRAY_WR        = 4899;
  localparam int GRAY_WG        = 9617;
  localparam int GRAY_WB        = 1868;
  localparam int GRAY_ROUND     = 8192;
  localparam int GRAY_SHIFT     = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd5;

  // Effective (clamped) configuration plus the precomputed bright limit.
  typedef struct packed {
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [8:0]  cell_w;
    logic [8:0]  cell_h;
    logic [8:0]  grid_c;
    logic [8:0]  grid_r;
    logic [22:0] limit;
  } bmtb_cfg_t;

  // Per-pixel position tag produced at accept time.
  typedef struct packed {
    logic       in_lat;
    logic       load;
    logic       done;
    logic       last;
    logic [7:0] col;
    logic [7:0] row;
  } bmtb_tag_t;

endpackage

// ===== hdl/block_mean_threshold_binarizer.sv =====
// Top level of the block mean threshold binarizer.
// Takes one BGR pixel per clock in raster order, converts it to gray with Q14 weights and
// sums it into the running sum of its lattice column; when the last pixel of a cell arrives
// one item leaves with dark = 1 if the cell sum is at most 127 * cell area. Throughput is
// one pixel per clock unless a finished cell meets a full result register and low
// out_tready; out_tvalid rises once a cell's last pixel has passed the input register,
// the stage 2 register (column-sum RAM read) and the result register. The 256 x 32 column
// sum RAM does one read and one write per cycle, with forwarding between adjacent pixels of
// the same column; per-entry valid bits make it read as zero after reset, so no clearing
// pass is needed. Configuration writes are taken every cycle and must happen while idle.
module block_mean_threshold_binarizer import bmtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // blue, green, red
  input  logic                  in_tuser,   // start_of_frame
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // dark, cell_col, cell_row, zero fill
  output logic                  out_tlast,  // last_cell
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bmtb_cfg_t  cfg;
  bmtb_tag_t  tag;
  logic       accept;
  logic       dark;
  logic [7:0] cell_col, cell_row;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  bmtb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  bmtb_pos u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sof    (in_tuser),
    .cfg    (cfg),
    .tag    (tag)
  );

  bmtb_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .blue      (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .red       (in_tdata[23:16]),
    .tag       (tag),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dark      (dark),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .last_cell (out_tlast)
  );

  assign out_tdata = {7'd0, cell_row, cell_col, dark};

endmodule

// ===== hdl/bmtb_cfg.sv =====
// Configuration registers with clamping and the cell threshold limit.
module bmtb_cfg import bmtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output bmtb_cfg_t             cfg
);

  logic [12:0] frame_w_r, frame_h_r;
  logic [8:0]  cell_w_r, cell_h_r, grid_c_r, grid_r_r;
  logic [16:0] area_r;
  logic [22:0] limit_r;
  logic [12:0] frame_nxt;
  logic [8:0]  cell_nxt, gcol_nxt, grow_nxt;

  function automatic logic [12:0] clamp13(input logic [12:0] v, input logic [12:0] hi);
    logic [12:0] res;
    if (v == 13'd0) res = 13'd1;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

  function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
    logic [8:0] res;
    if (v == 9'd0) res = 9'd1;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

  assign frame_nxt = clamp13(wr_data, 13'(MAX_FRAME_SIDE));
  assign cell_nxt  = clamp9(wr_data[8:0], 9'(MAX_CELL_SIDE));
  assign gcol_nxt  = clamp9(wr_data[8:0], 9'(MAX_GRID_COLS));
  assign grow_nxt  = clamp9(wr_data[8:0], 9'(MAX_GRID_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= 13'd640;
      frame_h_r <= 13'd480;
      cell_w_r  <= 9'd10;
      cell_h_r  <= 9'd10;
      grid_c_r  <= 9'd64;
      grid_r_r  <= 9'd48;
      area_r    <= 17'd100;
      limit_r   <= 23'(GRAY_THRESHOLD * 100);
    end else begin
      if (wr_en) begin
        unique case (wr_idx)
          REG_FRAME_WIDTH:  frame_w_r <= frame_nxt;
          REG_FRAME_HEIGHT: frame_h_r <= frame_nxt;
          REG_CELL_WIDTH:   cell_w_r  <= cell_nxt;
          REG_CELL_HEIGHT:  cell_h_r  <= cell_nxt;
          REG_GRID_COLS:    grid_c_r  <= gcol_nxt;
          REG_GRID_ROWS:    grid_r_r  <= grow_nxt;
          default: ;
        endcase
      end
      area_r  <= 17'(cell_w_r) * 17'(cell_h_r);
      // 127 * area as (area << 7) - area
      limit_r <= 23'({area_r, 7'd0} - {7'd0, area_r});
    end
  end

  assign cfg.frame_w = frame_w_r;
  assign cfg.frame_h = frame_h_r;
  assign cfg.cell_w  = cell_w_r;
  assign cfg.cell_h  = cell_h_r;
  assign cfg.grid_c  = grid_c_r;
  assign cfg.grid_r  = grid_r_r;
  assign cfg.limit   = limit_r;

endmodule

// ===== hdl/bmtb_pos.sv =====
// Raster position and cell lattice counters, tagging each accepted pixel.
module bmtb_pos import bmtb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic      sof,
  input  bmtb_cfg_t cfg,
  output bmtb_tag_t tag
);

  logic [11:0] px_r, px_nxt, py_r, py_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [8:0]  col_r, col_nxt, row_r, row_nxt;

  logic [11:0] px_e, py_e;
  logic [7:0]  x_e, y_e;
  logic [8:0]  col_e, row_e;
  logic [8:0]  x_inc, y_inc;
  logic [12:0] px_inc, py_inc;

  assign px_e  = sof ? '0 : px_r;
  assign py_e  = sof ? '0 : py_r;
  assign x_e   = sof ? '0 : x_r;
  assign y_e   = sof ? '0 : y_r;
  assign col_e = sof ? '0 : col_r;
  assign row_e = sof ? '0 : row_r;

  assign tag.in_lat = (col_e < cfg.grid_c) && (row_e < cfg.grid_r);
  assign tag.load   = (x_e == 8'd0) && (y_e == 8'd0);
  assign tag.done   = ({1'b0, x_e} == cfg.cell_w - 9'd1) && ({1'b0, y_e} == cfg.cell_h - 9'd1);
  assign tag.last   = (col_e == cfg.grid_c - 9'd1) && (row_e == cfg.grid_r - 9'd1);
  assign tag.col    = col_e[7:0];
  assign tag.row    = row_e[7:0];

  assign x_inc  = {1'b0, x_e} + 9'd1;
  assign y_inc  = {1'b0, y_e} + 9'd1;
  assign px_inc = {1'b0, px_e} + 13'd1;
  assign py_inc = {1'b0, py_e} + 13'd1;

  always_comb begin
    x_nxt   = x_inc[7:0];
    y_nxt   = y_e;
    px_nxt  = px_inc[11:0];
    py_nxt  = py_e;
    col_nxt = col_e;
    row_nxt = row_e;
    if (x_inc >= cfg.cell_w) begin
      x_nxt = '0;
      if (col_e < 9'(MAX_GRID_COLS)) col_nxt = col_e + 9'd1;
    end
    if (px_inc >= cfg.frame_w) begin
      px_nxt  = '0;
      x_nxt   = '0;
      col_nxt = '0;
      y_nxt   = y_inc[7:0];
      if (y_inc >= cfg.cell_h) begin
        y_nxt = '0;
        if (row_e < 9'(MAX_GRID_ROWS)) row_nxt = row_e + 9'd1;
      end
      py_nxt = py_inc[11:0];
      if (py_inc >= cfg.frame_h) begin
        px_nxt  = '0;
        py_nxt  = '0;
        x_nxt   = '0;
        y_nxt   = '0;
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r  <= '0;
      py_r  <= '0;
      x_r   <= '0;
      y_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/bmtb_accum.sv =====
// Gray conversion, column-sum RAM update with forwarding, threshold and result register.
module bmtb_accum import bmtb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  bmtb_tag_t  tag,
  input  bmtb_cfg_t  cfg,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       dark,
  output logic [7:0] cell_col,
  output logic [7:0] cell_row,
  output logic       last_cell
);

  // stage 1: pixel and tag
  logic        s1_v_r;
  logic [7:0]  s1_blue_r, s1_green_r, s1_red_r;
  bmtb_tag_t   s1_tag_r;
  // stage 2: gray and tag, column sum read back
  logic        s2_v_r;
  logic [7:0]  s2_gray_r;
  bmtb_tag_t   s2_tag_r;
  // result register
  logic        out_v_r, dark_r, last_r;
  logic [7:0]  col_r, row_r;

  logic [31:0] sum_mem [MAX_GRID_COLS];
  logic [MAX_GRID_COLS-1:0] vld_r;
  logic [31:0] rd_r, fwd_val_r;
  logic        rdv_r, fwd_r;

  logic        out_free, s2_res, s2_go, s2_free, s1_go, s1_free, wr;
  logic [7:0]  rd_addr;
  logic [21:0] gray_acc;
  logic [7:0]  gray;
  logic [31:0] old_sum, sum_s2;
  logic        dark_s2;

  assign out_free = !out_v_r || out_ready;
  assign s2_res   = s2_tag_r.in_lat && s2_tag_r.done;
  assign s2_go    = s2_v_r && (!s2_res || out_free);
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_go;
  assign in_ready = s1_free;
  assign wr       = s2_go && s2_tag_r.in_lat;

  assign gray_acc = 22'(GRAY_WR * 32'(s1_red_r) + GRAY_WG * 32'(s1_green_r)
                        + GRAY_WB * 32'(s1_blue_r) + GRAY_ROUND);
  assign gray     = gray_acc[GRAY_SHIFT +: 8];

  // address of the item that sits in stage 2 during the next cycle
  assign rd_addr = s1_go ? s1_tag_r.col : s2_tag_r.col;

  assign old_sum = fwd_r ? fwd_val_r : (rdv_r ? rd_r : 32'd0);
  assign sum_s2  = s2_tag_r.load ? 32'(s2_gray_r) : old_sum + 32'(s2_gray_r);
  assign dark_s2 = !(sum_s2 > 32'(cfg.limit));

  always_ff @(posedge clk) begin
    rd_r <= sum_mem[rd_addr];
    if (wr) begin
      sum_mem[s2_tag_r.col] <= sum_s2;
    end
  end

  always_ff @(posedge clk) begin
    fwd_val_r <= sum_s2;
    if (s1_free && in_valid) begin
      s1_blue_r  <= blue;
      s1_green_r <= green;
      s1_red_r   <= red;
      s1_tag_r   <= tag;
    end
    if (s1_go) begin
      s2_gray_r <= gray;
      s2_tag_r  <= s1_tag_r;
    end
    if (out_free && s2_v_r && s2_res) begin
      dark_r <= dark_s2;
      col_r  <= s2_tag_r.col;
      row_r  <= s2_tag_r.row;
      last_r <= s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      vld_r   <= '0;
      rdv_r   <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= in_valid;
      if (s2_free) s2_v_r <= s1_go;
      if (out_free) out_v_r <= s2_v_r && s2_res;
      if (wr) vld_r[s2_tag_r.col] <= 1'b1;
      rdv_r <= vld_r[rd_addr];
      fwd_r <= s1_go && wr && (s1_tag_r.col == s2_tag_r.col);
    end
  end

  assign out_valid = out_v_r;
  assign dark      = dark_r;
  assign cell_col  = col_r;
  assign cell_row  = row_r;
  assign last_cell = last_r;

`ifndef SYNTH
  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s2_v_r)
    else $error("forward flag without an item in stage 2");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_res) |=> out_v_r)
    else $error("finished cell lost on the way to the result register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with room in the pipeline");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> vld_r[$past(s2_tag_r.col)])
    else $error("written column not marked valid");
`endif

endmodule
